>>> src/correlation_ratio_from_histograms_assert.svh
// ----------------------------------------------------------------------------
// Correlation ratio assertion macros
// Concurrent assertion shorthands used by the correlation ratio block.
// ----------------------------------------------------------------------------
`ifndef CORRELATION_RATIO_FROM_HISTOGRAMS_ASSERT_SVH
`define CORRELATION_RATIO_FROM_HISTOGRAMS_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CRFH_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CRFH_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> src/crfh_pkg.sv
// ----------------------------------------------------------------------------
// crfh_pkg
// Shared types and fixed field widths of the correlation ratio block.
// ----------------------------------------------------------------------------
`default_nettype none

package crfh_pkg;

   localparam int VAL_W   = 25;
   localparam int S1_W    = 41;
   localparam int S2_W    = 49;
   localparam int SQ_W    = 41;
   localparam int SQ_HALF = 21;
   localparam int RATIO_W = 32;

   typedef enum logic [2:0] {
      CMD_CLEAR    = 3'd0,
      CMD_CELL     = 3'd1,
      CMD_ROW_MARG = 3'd2,
      CMD_COL_MARG = 3'd3,
      CMD_COMPUTE  = 3'd4
   } crfh_cmd_type;

   typedef enum logic [1:0] {
      STAT_OK       = 2'd0,
      STAT_ZERO_VAR = 2'd1,
      STAT_SAT      = 2'd2
   } crfh_stat_type;

   // One row entry of the row memory.
   typedef struct packed {
      logic [S2_W-1:0]  s2;
      logic [S1_W-1:0]  s1;
      logic [VAL_W-1:0] p;
   } crfh_row_type;

   typedef struct packed {
      logic busy;
      logic done;
   } crfh_unit_stat_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_RD,
      ST_WR,
      ST_C_RD,
      ST_C_LOAD,
      ST_C_COL,
      ST_C_SQ,
      ST_C_DIV,
      ST_C_ACC,
      ST_V_START,
      ST_V_SQ,
      ST_V_VAR,
      ST_V_CHK,
      ST_R_DIV,
      ST_OUT
   } crfh_state_type;

endpackage

`default_nettype wire

>>> src/crfh_ram.sv
// ----------------------------------------------------------------------------
// crfh_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module crfh_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

>>> src/crfh_sqr.sv
// ----------------------------------------------------------------------------
// crfh_sqr
// Two-stage squarer for 41-bit moments, split into two partial products.
// ----------------------------------------------------------------------------
`default_nettype none

module crfh_sqr (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic [crfh_pkg::SQ_W-1:0]   operand,
   output logic      [2*crfh_pkg::SQ_W-1:0] result,
   output crfh_pkg::crfh_unit_stat_type     stat
);

   localparam int W  = crfh_pkg::SQ_W;
   localparam int H  = crfh_pkg::SQ_HALF;
   localparam int LW = W + H;
   localparam int HW = 2 * W - H;

   logic [W-1:0]   a_ff, a_in;
   logic           v1_ff, v1_in;
   logic           v2_ff, v2_in;
   logic [LW-1:0]  lo_ff, lo_in;
   logic [HW-1:0]  hi_ff, hi_in;
   logic [2*W-1:0] sum;

   always_comb begin
      a_in  = start ? operand : a_ff;
      v1_in = start;
      v2_in = v1_ff;
      lo_in = LW'(a_ff) * LW'(a_ff[H-1:0]);
      hi_in = HW'(a_ff) * HW'(a_ff[W-1:H]);
      // The partial products are registered; the final sum is formed in the
      // cycle in which done is high.
      sum   = (2*W)'(lo_ff) + ((2*W)'(hi_ff) << H);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff <= a_in;
      if (v1_ff) begin
         lo_ff <= lo_in;
         hi_ff <= hi_in;
      end
   end

   assign result    = sum;
   assign stat.busy = v1_ff;
   assign stat.done = v2_ff;

endmodule

`default_nettype wire

>>> src/crfh_div.sv
// ----------------------------------------------------------------------------
// crfh_div
// Shared restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module crfh_div #(
   parameter int NUM_W = 82,
   parameter int DEN_W = 49
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   input  wire logic [NUM_W-1:0]        num,
   input  wire logic [DEN_W-1:0]        den,
   output logic      [NUM_W-1:0]        quot,
   output crfh_pkg::crfh_unit_stat_type stat
);

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [NUM_W-1:0] quot_ff, quot_in;
   logic [DEN_W:0]   rem_sh;
   logic [DEN_W:0]   diff;
   logic             ge;

   always_comb begin
      rem_sh  = {rem_ff, quot_ff[NUM_W-1]};
      diff    = rem_sh - {1'b0, den_ff};
      ge      = rem_sh >= {1'b0, den_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quot_in = quot_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(NUM_W);
         rem_in  = '0;
         den_in  = den;
         quot_in = num;
      end else if (busy_ff) begin
         cnt_in  = cnt_ff - 1'b1;
         rem_in  = ge ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
         quot_in = {quot_ff[NUM_W-2:0], ge};
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      quot_ff <= quot_in;
   end

   assign quot      = quot_ff;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule

`default_nettype wire

>>> src/correlation_ratio_from_histograms.sv
// ----------------------------------------------------------------------------
// correlation_ratio_from_histograms
// Correlation ratio of a joint histogram with per-row moment memories.
// ----------------------------------------------------------------------------
// Joint cells, row marginals and column marginals are written through the
// request stream; a compute command returns one response with the ratio in
// signed Q8.24 and a status code. After reset and after every clear command a
// clearing pass over all LEVELS entries runs before the next request is taken.
// A cell or marginal write passes through accept, memory read and write back.
// Compute walks the row memory: each row is read, loaded and its column term
// added; a row whose marginal is nonzero is then squared, divided and summed.
// NUM_W = max(82, 63 + FRAC_BITS) is the length of the bit-serial divider that
// forms s1*s1/p1 and, after the column variance, the final ratio division.
// ----------------------------------------------------------------------------
`default_nettype none

module correlation_ratio_from_histograms #(
   parameter int LEVELS    = 256,
   parameter int FRAC_BITS = 24
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [47:0] req_tdata,  // row[7:0], col[15:8], value[40:16]
   input  wire logic [2:0]  req_tuser,  // cmd[2:0]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,  // ratio[31:0]
   output logic [1:0]       rsp_tuser   // status[1:0]
);

   localparam int AW    = $clog2(LEVELS);
   localparam int NUM_W = (63 + FRAC_BITS > 82) ? 63 + FRAC_BITS : 82;
   localparam int DEN_W = crfh_pkg::S2_W;
   localparam int ROW_W = $bits(crfh_pkg::crfh_row_type);
   localparam int VW    = crfh_pkg::VAL_W;
   localparam int SW    = 2 * crfh_pkg::SQ_W;

   localparam logic [NUM_W-1:0]  LIM_N   = NUM_W'(1) << 62;
   localparam logic [SW-1:0]     LIM_SQ  = SW'(1) << 62;
   localparam logic [62:0]       LIM_63  = 63'(1) << 62;
   localparam logic signed [65:0] ACC_LIM = 66'sh4000_0000_0000_0000;

   crfh_pkg::crfh_state_type state_ff, state_in;
   crfh_pkg::crfh_cmd_type   cmd_ff, cmd_in, req_cmd;
   crfh_pkg::crfh_stat_type  res_status_ff, res_status_in;
   crfh_pkg::crfh_stat_type  rsp_status_ff, rsp_status_in;
   crfh_pkg::crfh_row_type   row_word, row_wword;
   crfh_pkg::crfh_unit_stat_type sq_stat, div_stat;

   logic [7:0]    row_ff, row_in, col_ff, col_in;
   logic [VW-1:0] val_ff, val_in;
   logic [AW-1:0] idx_ff, idx_in;
   logic          ovf_ff, ovf_in;
   logic          sat_ff, sat_in;
   logic [32:0]   cv_ff, cv_in;
   logic [15:0]   cc_ff, cc_in;
   logic [40:0]   ccv;
   logic [41:0]   s1_sum;
   logic [49:0]   s2_sum;
   logic [40:0]   s1_ff, s1_in;
   logic [48:0]   s2_ff, s2_in;
   logic [VW-1:0] p_ff, p_in, p2_ff, p2_in;
   logic [32:0]   jp_ff, jp_in;
   logic [15:0]   jj_ff, jj_in;
   logic [40:0]   jjp;
   logic [40:0]   m_ff, m_in;
   logic [48:0]   t2_ff, t2_in;
   logic [62:0]   qc_ff, qc_in;
   logic [62:0]   shc_ff, shc_in;
   logic [SW-1:0] sh;
   logic signed [63:0] acc_ff, acc_in;
   logic signed [63:0] var_ff, var_in;
   logic signed [65:0] acc_sum;
   logic [62:0]   mag;
   logic [NUM_W-1:0] qmax_n;
   logic [31:0]   qm;
   logic [31:0]   res_ratio_ff, res_ratio_in;
   logic [31:0]   rsp_ratio_ff, rsp_ratio_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          col_ok, row_ok, colv, last_row;
   logic [7:0]    j;

   logic          row_we, col_we;
   logic [AW-1:0] row_waddr, col_waddr, row_raddr;
   logic [ROW_W-1:0] row_wdata, row_rdata;
   logic [VW-1:0] col_wdata, col_rdata;

   logic          sq_start;
   logic [crfh_pkg::SQ_W-1:0] sq_op;
   logic [SW-1:0] sq_res;
   logic          div_start;
   logic [NUM_W-1:0] div_num, div_quot;
   logic [DEN_W-1:0] div_den;

   crfh_ram #(.WIDTH(ROW_W), .DEPTH(LEVELS)) u_row_ram (
      .clock (clock),
      .we    (row_we),
      .waddr (row_waddr),
      .wdata (row_wdata),
      .raddr (row_raddr),
      .rdata (row_rdata)
   );

   crfh_ram #(.WIDTH(VW), .DEPTH(LEVELS)) u_col_ram (
      .clock (clock),
      .we    (col_we),
      .waddr (col_waddr),
      .wdata (col_wdata),
      .raddr (idx_ff),
      .rdata (col_rdata)
   );

   crfh_sqr u_sqr (
      .clock   (clock),
      .reset   (reset),
      .start   (sq_start),
      .operand (sq_op),
      .result  (sq_res),
      .stat    (sq_stat)
   );

   crfh_div #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .quot  (div_quot),
      .stat  (div_stat)
   );

   always_comb begin
      req_cmd  = crfh_pkg::crfh_cmd_type'(req_tuser);
      row_ok   = 32'(req_tdata[7:0]) < LEVELS;
      col_ok   = 32'(req_tdata[15:8]) < LEVELS;
      row_word = crfh_pkg::crfh_row_type'(row_rdata);
      ccv      = 41'(cc_ff) * 41'(val_ff);
      s1_sum   = 42'(row_word.s1) + 42'(cv_ff);
      s2_sum   = 50'(row_word.s2) + 50'(ccv);
      j        = 8'(idx_ff);
      colv     = 32'(idx_ff) < 256;
      jjp      = 41'(jj_ff) * 41'(p2_ff);
      last_row = idx_ff == AW'(LEVELS - 1);
      acc_sum  = $signed({{2{acc_ff[63]}}, acc_ff}) + $signed({17'b0, s2_ff})
                 - $signed({3'b0, qc_ff});
      sh       = sq_res >> FRAC_BITS;
      mag      = acc_ff[63] ? 63'(-acc_ff) : acc_ff[62:0];
      qmax_n   = acc_ff[63] ? NUM_W'(32'h8000_0000) : NUM_W'(32'h7FFF_FFFF);
      qm       = (div_quot > qmax_n) ? qmax_n[31:0] : div_quot[31:0];

      state_in      = state_ff;
      cmd_in        = cmd_ff;
      row_in        = row_ff;
      col_in        = col_ff;
      val_in        = val_ff;
      idx_in        = idx_ff;
      ovf_in        = ovf_ff;
      sat_in        = sat_ff;
      cv_in         = cv_ff;
      cc_in         = cc_ff;
      s1_in         = s1_ff;
      s2_in         = s2_ff;
      p_in          = p_ff;
      p2_in         = p2_ff;
      jp_in         = jp_ff;
      jj_in         = jj_ff;
      m_in          = m_ff;
      t2_in         = t2_ff;
      qc_in         = qc_ff;
      shc_in        = shc_ff;
      acc_in        = acc_ff;
      var_in        = var_ff;
      res_ratio_in  = res_ratio_ff;
      res_status_in = res_status_ff;
      rsp_ratio_in  = rsp_ratio_ff;
      rsp_status_in = rsp_status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;

      row_we    = 1'b0;
      col_we    = 1'b0;
      row_waddr = AW'(row_ff);
      col_waddr = AW'(col_ff);
      row_raddr = AW'(row_ff);
      row_wword = row_word;
      col_wdata = val_ff;
      sq_start  = 1'b0;
      sq_op     = s1_ff;
      div_start = 1'b0;
      div_num   = NUM_W'(sq_res);
      div_den   = DEN_W'(p_ff);

      unique case (state_ff)
         crfh_pkg::ST_CLEAR: begin
            row_we    = 1'b1;
            col_we    = 1'b1;
            row_waddr = idx_ff;
            col_waddr = idx_ff;
            row_wword = '0;
            col_wdata = '0;
            idx_in    = idx_ff + 1'b1;
            if (last_row) begin
               idx_in   = '0;
               state_in = crfh_pkg::ST_IDLE;
            end
         end
         crfh_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               cmd_in = req_cmd;
               row_in = req_tdata[7:0];
               col_in = req_tdata[15:8];
               val_in = req_tdata[40:16];
               unique case (req_cmd)
                  crfh_pkg::CMD_CLEAR: begin
                     idx_in   = '0;
                     ovf_in   = 1'b0;
                     state_in = crfh_pkg::ST_CLEAR;
                  end
                  crfh_pkg::CMD_CELL: begin
                     if (row_ok && col_ok) state_in = crfh_pkg::ST_RD;
                  end
                  crfh_pkg::CMD_ROW_MARG: begin
                     if (row_ok) state_in = crfh_pkg::ST_RD;
                  end
                  crfh_pkg::CMD_COL_MARG: begin
                     if (col_ok) state_in = crfh_pkg::ST_RD;
                  end
                  crfh_pkg::CMD_COMPUTE: begin
                     idx_in   = '0;
                     acc_in   = '0;
                     m_in     = '0;
                     t2_in    = '0;
                     sat_in   = 1'b0;
                     state_in = crfh_pkg::ST_C_RD;
                  end
                  default: begin
                  end
               endcase
            end
         end
         crfh_pkg::ST_RD: begin
            cv_in    = 33'(col_ff) * 33'(val_ff);
            cc_in    = 16'(col_ff) * 16'(col_ff);
            state_in = crfh_pkg::ST_WR;
         end
         crfh_pkg::ST_WR: begin
            state_in = crfh_pkg::ST_IDLE;
            unique case (cmd_ff)
               crfh_pkg::CMD_CELL: begin
                  row_we = 1'b1;
                  if (s1_sum[41]) begin
                     row_wword.s1 = '1;
                     ovf_in       = 1'b1;
                  end else begin
                     row_wword.s1 = s1_sum[40:0];
                  end
                  if (s2_sum[49]) begin
                     row_wword.s2 = '1;
                     ovf_in       = 1'b1;
                  end else begin
                     row_wword.s2 = s2_sum[48:0];
                  end
               end
               crfh_pkg::CMD_ROW_MARG: begin
                  row_we      = 1'b1;
                  row_wword.p = val_ff;
               end
               crfh_pkg::CMD_COL_MARG: begin
                  col_we = 1'b1;
               end
               default: begin
               end
            endcase
         end
         crfh_pkg::ST_C_RD: begin
            row_raddr = idx_ff;
            state_in  = crfh_pkg::ST_C_LOAD;
         end
         crfh_pkg::ST_C_LOAD: begin
            s1_in    = row_word.s1;
            s2_in    = row_word.s2;
            p_in     = row_word.p;
            p2_in    = col_rdata;
            jp_in    = colv ? 33'(j) * 33'(col_rdata) : '0;
            jj_in    = colv ? 16'(j) * 16'(j) : '0;
            state_in = crfh_pkg::ST_C_COL;
         end
         crfh_pkg::ST_C_COL: begin
            m_in  = m_ff + 41'(jp_ff);
            t2_in = t2_ff + 49'(jjp);
            if (p_ff == '0) begin
               idx_in   = last_row ? '0 : idx_ff + 1'b1;
               state_in = last_row ? crfh_pkg::ST_V_START : crfh_pkg::ST_C_RD;
            end else begin
               sq_start = 1'b1;
               state_in = crfh_pkg::ST_C_SQ;
            end
         end
         crfh_pkg::ST_C_SQ: begin
            if (sq_stat.done) begin
               div_start = 1'b1;
               state_in  = crfh_pkg::ST_C_DIV;
            end
         end
         crfh_pkg::ST_C_DIV: begin
            if (div_stat.done) begin
               if (div_quot > LIM_N) begin
                  qc_in  = LIM_63;
                  sat_in = 1'b1;
               end else begin
                  qc_in = div_quot[62:0];
               end
               state_in = crfh_pkg::ST_C_ACC;
            end
         end
         crfh_pkg::ST_C_ACC: begin
            if (acc_sum > ACC_LIM) begin
               acc_in = 64'(ACC_LIM);
               sat_in = 1'b1;
            end else if (acc_sum < -ACC_LIM) begin
               acc_in = 64'(-ACC_LIM);
               sat_in = 1'b1;
            end else begin
               acc_in = 64'(acc_sum);
            end
            idx_in   = last_row ? '0 : idx_ff + 1'b1;
            state_in = last_row ? crfh_pkg::ST_V_START : crfh_pkg::ST_C_RD;
         end
         crfh_pkg::ST_V_START: begin
            sq_start = 1'b1;
            sq_op    = m_ff;
            state_in = crfh_pkg::ST_V_SQ;
         end
         crfh_pkg::ST_V_SQ: begin
            if (sq_stat.done) begin
               if (sh > LIM_SQ) begin
                  shc_in = LIM_63;
                  sat_in = 1'b1;
               end else begin
                  shc_in = sh[62:0];
               end
               state_in = crfh_pkg::ST_V_VAR;
            end
         end
         crfh_pkg::ST_V_VAR: begin
            var_in   = $signed({15'b0, t2_ff}) - $signed({1'b0, shc_ff});
            state_in = crfh_pkg::ST_V_CHK;
         end
         crfh_pkg::ST_V_CHK: begin
            if (var_ff[63] || var_ff == '0) begin
               res_ratio_in  = '0;
               res_status_in = crfh_pkg::STAT_ZERO_VAR;
               state_in      = crfh_pkg::ST_OUT;
            end else begin
               div_start = 1'b1;
               div_num   = NUM_W'(mag) << FRAC_BITS;
               div_den   = var_ff[DEN_W-1:0];
               state_in  = crfh_pkg::ST_R_DIV;
            end
         end
         crfh_pkg::ST_R_DIV: begin
            if (div_stat.done) begin
               res_ratio_in  = acc_ff[63] ? (32'd0 - qm) : qm;
               res_status_in = (sat_ff || ovf_ff || div_quot > qmax_n) ?
                               crfh_pkg::STAT_SAT : crfh_pkg::STAT_OK;
               state_in      = crfh_pkg::ST_OUT;
            end
         end
         crfh_pkg::ST_OUT: begin
            // The previous response must be gone before this one is loaded.
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_ratio_in  = res_ratio_ff;
               rsp_status_in = res_status_ff;
               state_in      = crfh_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = crfh_pkg::ST_IDLE;
         end
      endcase

      row_wdata = row_wword;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= crfh_pkg::ST_CLEAR;
         idx_ff       <= '0;
         ovf_ff       <= 1'b0;
         sat_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         ovf_ff       <= ovf_in;
         sat_ff       <= sat_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      row_ff        <= row_in;
      col_ff        <= col_in;
      val_ff        <= val_in;
      cv_ff         <= cv_in;
      cc_ff         <= cc_in;
      s1_ff         <= s1_in;
      s2_ff         <= s2_in;
      p_ff          <= p_in;
      p2_ff         <= p2_in;
      jp_ff         <= jp_in;
      jj_ff         <= jj_in;
      m_ff          <= m_in;
      t2_ff         <= t2_in;
      qc_ff         <= qc_in;
      shc_ff        <= shc_in;
      acc_ff        <= acc_in;
      var_ff        <= var_in;
      res_ratio_ff  <= res_ratio_in;
      res_status_ff <= res_status_in;
      rsp_ratio_ff  <= rsp_ratio_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign req_tready = state_ff == crfh_pkg::ST_IDLE;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_ratio_ff;
   assign rsp_tuser  = rsp_status_ff;

`include "correlation_ratio_from_histograms_assert.svh"

   `CRFH_ASSERT_SAME(a_div_done_state, clock, reset, div_stat.done, (state_ff == crfh_pkg::ST_C_DIV || state_ff == crfh_pkg::ST_R_DIV), "divider finished outside a divide state")
   `CRFH_ASSERT_SAME(a_div_running, clock, reset, (state_ff == crfh_pkg::ST_C_DIV || state_ff == crfh_pkg::ST_R_DIV), (div_stat.busy || div_stat.done), "waiting on an idle divider")
   `CRFH_ASSERT_SAME(a_sqr_running, clock, reset, (state_ff == crfh_pkg::ST_C_SQ || state_ff == crfh_pkg::ST_V_SQ), (sq_stat.busy || sq_stat.done), "waiting on an idle squarer")
   `CRFH_ASSERT_NEXT(a_rsp_kept, clock, reset, (state_ff == crfh_pkg::ST_OUT && rsp_valid_ff && !rsp_tready), (state_ff == crfh_pkg::ST_OUT && rsp_valid_ff), "pending response overwritten")
   `CRFH_ASSERT_NEXT(a_compute_start, clock, reset, (req_tvalid && req_tready && req_tuser == crfh_pkg::CMD_COMPUTE), (state_ff == crfh_pkg::ST_C_RD && idx_ff == '0), "compute did not start at the first row")

endmodule

`default_nettype wire
